[src/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, widths and the control program of the balance/speed
// cascade controller.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [STEP_W-1:0] STEP_SKIP = STEP_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_OFFSET   = 4'd0,
        CFG_BALANCE_KP     = 4'd1,
        CFG_BALANCE_KD     = 4'd2,
        CFG_SPEED_KP       = 4'd3,
        CFG_SPEED_KI       = 4'd4,
        CFG_SMOOTHING      = 4'd5,
        CFG_INTEGRAL_LIMIT = 4'd6,
        CFG_MOVEMENT       = 4'd7
    } cfg_idx_t;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        M_NONE,
        M_ANG,
        M_RATE,
        M_FS,
        M_SUM,
        M_FSK,
        M_ILO,
        M_IHI
    } mul_sel_t;

    // accumulator and state operations
    typedef enum logic [3:0] {
        A_NONE,
        A_LD0,
        A_LD8,
        A_LD15,
        A_ADD0,
        A_ADD18,
        A_BAL,
        A_RND,
        A_FILT,
        A_INT1,
        A_INT2,
        A_CLAMP,
        A_VEL,
        A_DRV
    } acc_op_t;

    typedef enum logic {
        J_NONE,
        J_PHASE0
    } jmp_t;

    typedef struct packed {
        mul_sel_t          msel;
        acc_op_t           aop;
        jmp_t              jmp;
        logic              last;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        mul_sel_t msel;
        acc_op_t  aop;
    } dp_cmd_t;

    function automatic uword_t prog_word(input logic [STEP_W-1:0] step);
        uword_t w;
        begin
            w = '{msel: M_NONE, aop: A_NONE, jmp: J_NONE, last: 1'b0, target: '0};
            case (step)
                5'd0:
                begin
                    w.msel   = M_ANG;
                    w.jmp    = J_PHASE0;
                    w.target = STEP_SKIP;
                end
                5'd1:
                begin
                    w.msel = M_RATE;
                    w.aop  = A_LD0;
                end
                5'd2:
                begin
                    w.msel = M_SUM;
                    w.aop  = A_ADD0;
                end
                5'd3:  w.aop = A_BAL;
                5'd4:
                begin
                    w.msel = M_FS;
                    w.aop  = A_LD15;
                end
                5'd5:  w.aop = A_ADD0;
                5'd6:  w.aop = A_RND;
                5'd7:  w.aop = A_FILT;
                5'd8:
                begin
                    w.msel = M_FSK;
                    w.aop  = A_INT1;
                end
                5'd9:  w.aop = A_INT2;
                5'd10: w.aop = A_CLAMP;
                5'd11:
                begin
                    w.msel = M_ILO;
                    w.aop  = A_LD8;
                end
                5'd12:
                begin
                    w.msel = M_IHI;
                    w.aop  = A_ADD0;
                end
                5'd13: w.aop = A_ADD18;
                5'd14: w.aop = A_VEL;
                5'd15:
                begin
                    w.aop  = A_DRV;
                    w.last = 1'b1;
                end
                5'd16: w.last = 1'b1;
                default: w.last = 1'b1;
            endcase
            return w;
        end
    endfunction

endpackage

[src/balance_speed_cascade_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance_speed_cascade_controller
// PD balance loop minus PI wheel-speed loop, run every second sensor tick by
// a microcoded sequencer over one shared 32x17 multiplier.
// ----------------------------------------------------------------------------
// computing tick: the result is produced by the 16-step program on the shared
//   multiplier and accumulator
// skipped tick: no result, step 0 jumps to the final step; one tick in flight at a time
// a pending result holds the last step until it is taken
// reset: asynchronous, clears phase, filter and integral, loads register defaults
module balance_speed_cascade_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [16:0]             tilt_angle,
    input  logic signed [19:0]             tilt_rate,
    input  logic signed [15:0]             left_count,
    input  logic signed [15:0]             right_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [23:0]             motor_drive
);
    import bsc_pkg::*;

    logic    busy;
    logic    start;
    logic    out_busy;
    dp_cmd_t cmd;

    assign in_ready = !busy;
    assign start    = in_valid && in_ready;

    bsc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_busy (out_busy),
        .busy     (busy),
        .cmd      (cmd)
    );

    bsc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .load        (start),
        .tilt_angle  (tilt_angle),
        .tilt_rate   (tilt_rate),
        .left_count  (left_count),
        .right_count (right_count),
        .cmd         (cmd),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .motor_drive (motor_drive),
        .out_busy    (out_busy)
    );

endmodule

[src/bsc_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_sequencer
// Step counter over the control program, tick phase and conditional jump.
// ----------------------------------------------------------------------------
module bsc_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             out_busy,
    output logic             busy,
    output bsc_pkg::dp_cmd_t cmd
);
    import bsc_pkg::*;

    logic              busy_reg, busy_next;
    logic              phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;
    logic              hold;

    assign uw   = prog_word(step_reg);
    assign hold = busy_reg && (uw.aop == A_DRV) && out_busy;
    assign busy = busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg && !hold)
        begin
            if (uw.last)
            begin
                busy_next  = 1'b0;
                phase_next = ~phase_reg;
            end
            else if ((uw.jmp == J_PHASE0) && !phase_reg)
            begin
                step_next = uw.target;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_comb
    begin
        if (busy_reg && !hold)
        begin
            cmd = '{msel: uw.msel, aop: uw.aop};
        end
        else
        begin
            cmd = '{msel: M_NONE, aop: A_NONE};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

endmodule

[src/bsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_datapath
// Configuration registers, shared multiplier, accumulator, loop state and
// output register.
// ----------------------------------------------------------------------------
module bsc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           load,
    input  logic signed [16:0]             tilt_angle,
    input  logic signed [19:0]             tilt_rate,
    input  logic signed [15:0]             left_count,
    input  logic signed [15:0]             right_count,
    input  bsc_pkg::dp_cmd_t               cmd,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [23:0]             motor_drive,
    output logic                           out_busy
);
    import bsc_pkg::*;

    logic signed [16:0] angle_offset_reg;
    logic [11:0]        bkp_reg, bkd_reg, skp_reg;
    logic [15:0]        ski_reg, smooth_reg;
    logic [19:0]        ilim_reg;
    logic signed [14:0] move_reg;

    logic signed [17:0] diff_reg;
    logic signed [19:0] rate_reg;
    logic signed [16:0] csum_reg;

    logic signed [16:0] weight;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] prod;
    logic signed [48:0] p_reg;
    logic signed [55:0] p_ext;

    logic signed [55:0] acc_reg, acc_next;
    logic signed [26:0] bal_reg, bal_next;
    logic signed [31:0] fs_reg, fs_next;
    logic signed [36:0] integ_reg, integ_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [23:0] out_data_reg, out_data_next;

    logic signed [55:0] bal_t;
    logic signed [55:0] vel_t;
    logic signed [40:0] filt_sh;
    logic signed [55:0] lim_pos;
    logic signed [55:0] lim_neg;
    logic signed [35:0] drv;

    assign weight = 17'sd32768 - $signed({1'b0, smooth_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.msel)
            M_ANG:
            begin
                mul_a = 32'(diff_reg);
                mul_b = $signed({5'b0, bkp_reg});
            end
            M_RATE:
            begin
                mul_a = 32'(rate_reg);
                mul_b = $signed({5'b0, bkd_reg});
            end
            M_FS:
            begin
                mul_a = fs_reg;
                mul_b = $signed({1'b0, smooth_reg});
            end
            M_SUM:
            begin
                mul_a = 32'(csum_reg);
                mul_b = weight;
            end
            M_FSK:
            begin
                mul_a = fs_reg;
                mul_b = $signed({5'b0, skp_reg});
            end
            M_ILO:
            begin
                mul_a = $signed({14'b0, integ_reg[17:0]});
                mul_b = $signed({1'b0, ski_reg});
            end
            M_IHI:
            begin
                mul_a = 32'($signed(integ_reg[36:18]));
                mul_b = $signed({1'b0, ski_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign p_ext = 56'(p_reg);

    assign bal_t   = acc_reg + (acc_reg[55] ? 56'sd255 : 56'sd0);
    assign vel_t   = acc_reg + (acc_reg[55] ? 56'sd8388607 : 56'sd0);
    assign filt_sh = $signed(acc_reg[55:15]);
    assign lim_pos = $signed({21'b0, ilim_reg, 15'b0});
    assign lim_neg = -lim_pos;
    assign drv     = 36'(bal_reg) - 36'($signed(acc_reg[34:0]));

    always_comb
    begin
        acc_next       = acc_reg;
        bal_next       = bal_reg;
        fs_next        = fs_reg;
        integ_next     = integ_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.aop)
            A_LD0:   acc_next = p_ext;
            A_LD8:   acc_next = p_ext <<< 8;
            A_LD15:  acc_next = p_ext <<< 15;
            A_ADD0:  acc_next = acc_reg + p_ext;
            A_ADD18: acc_next = acc_reg + (p_ext <<< 18);
            A_BAL:   bal_next = $signed(bal_t[34:8]);
            A_RND:   acc_next = acc_reg + 56'sd16384;
            A_FILT:
            begin
                if ((filt_sh[40:31] == '0) || (filt_sh[40:31] == '1))
                begin
                    fs_next = filt_sh[31:0];
                end
                else if (filt_sh[40])
                begin
                    fs_next = {1'b1, 31'b0};
                end
                else
                begin
                    fs_next = {1'b0, {31{1'b1}}};
                end
            end
            A_INT1:  acc_next = 56'(integ_reg) + 56'(fs_reg);
            A_INT2:  acc_next = acc_reg - (56'(move_reg) <<< 15);
            A_CLAMP:
            begin
                if (acc_reg > lim_pos)
                begin
                    integ_next = lim_pos[36:0];
                end
                else if (acc_reg < lim_neg)
                begin
                    integ_next = lim_neg[36:0];
                end
                else
                begin
                    integ_next = acc_reg[36:0];
                end
            end
            A_VEL:   acc_next = vel_t >>> 23;
            A_DRV:
            begin
                out_valid_next = 1'b1;
                if ((drv[35:23] == '0) || (drv[35:23] == '1))
                begin
                    out_data_next = drv[23:0];
                end
                else if (drv[35])
                begin
                    out_data_next = {1'b1, 23'b0};
                end
                else
                begin
                    out_data_next = {1'b0, {23{1'b1}}};
                end
            end
            default: acc_next = acc_reg;
        endcase
    end

    // configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_offset_reg <= '0;
            bkp_reg          <= 12'd300;
            bkd_reg          <= 12'd1;
            skp_reg          <= 12'd80;
            ski_reg          <= 16'd102;
            smooth_reg       <= 16'd29491;
            ilim_reg         <= 20'd10000;
            move_reg         <= '0;
            fs_reg           <= '0;
            integ_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ANGLE_OFFSET:   angle_offset_reg <= $signed(cfg_data[16:0]);
                    CFG_BALANCE_KP:     bkp_reg          <= cfg_data[11:0];
                    CFG_BALANCE_KD:     bkd_reg          <= cfg_data[11:0];
                    CFG_SPEED_KP:       skp_reg          <= cfg_data[11:0];
                    CFG_SPEED_KI:       ski_reg          <= cfg_data[15:0];
                    CFG_SMOOTHING:      smooth_reg       <= cfg_data[15:0];
                    CFG_INTEGRAL_LIMIT: ilim_reg         <= cfg_data[19:0];
                    CFG_MOVEMENT:       move_reg         <= $signed(cfg_data[14:0]);
                    default:            move_reg         <= move_reg;
                endcase
            end
            fs_reg        <= fs_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diff_reg <= 18'(tilt_angle) - 18'(angle_offset_reg);
            rate_reg <= tilt_rate;
            csum_reg <= 17'(right_count) - 17'(left_count);
        end
        if (cmd.msel != M_NONE)
        begin
            p_reg <= prod;
        end
        acc_reg      <= acc_next;
        bal_reg      <= bal_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign motor_drive = out_data_reg;
    assign out_busy    = out_valid_reg && !out_ready;

endmodule

[src/bsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on transfer ordering of the cascade controller.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [23:0] motor_drive
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motor_drive))
        else $error("result changed while stalled");

    // one tick in flight
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a tick is in flight");

    // a result appears only at the end of a tick
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // no result right after an input transfer
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early after input transfer");

endmodule

bind balance_speed_cascade_controller bsc_checker u_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the balance/speed cascade controller. Sensor ticks
// and motor drive results move over valid/ready with random idle bursts on
// both sides. A scoreboard tracks tick phase, filter, integral and register
// settings in fixed point and checks every drive value in order. Directed
// extremes run first, then random ticks over several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import bsc_pkg::*;

    localparam longint Q15_ONE      = 64'sd32768;
    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -WORD_MAX - 64'sd1;
    localparam longint DRIVE_MAX    = 64'sd8388607;
    localparam longint DRIVE_MIN    = -64'sd8388608;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_BASE = 4'd8;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     PHASES        = 8;
    localparam int     TICKS_PER_PHASE = 185;
    localparam longint TIMEOUT_NS    = 2000000;

    class drive_scoreboard;
        logic signed [16:0] angle_offset;
        logic [11:0]        balance_kp;
        logic [11:0]        balance_kd;
        logic [11:0]        speed_kp;
        logic [15:0]        speed_ki;
        logic [15:0]        smoothing;
        logic [19:0]        integral_limit;
        logic signed [14:0] movement;
        bit                 odd_tick;
        longint             filt_speed;
        longint             speed_int;
        logic signed [23:0] pending_drives[$];
        int                 errors;

        function new();
            angle_offset   = '0;
            balance_kp     = 12'd300;
            balance_kd     = 12'd1;
            speed_kp       = 12'd80;
            speed_ki       = 16'd102;
            smoothing      = 16'd29491;
            integral_limit = 20'd10000;
            movement       = '0;
            odd_tick       = 1'b0;
            filt_speed     = 0;
            speed_int      = 0;
            errors         = 0;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ANGLE_OFFSET:   angle_offset   = data[16:0];
                CFG_BALANCE_KP:     balance_kp     = data[11:0];
                CFG_BALANCE_KD:     balance_kd     = data[11:0];
                CFG_SPEED_KP:       speed_kp       = data[11:0];
                CFG_SPEED_KI:       speed_ki       = data[15:0];
                CFG_SMOOTHING:      smoothing      = data[15:0];
                CFG_INTEGRAL_LIMIT: integral_limit = data[19:0];
                CFG_MOVEMENT:       movement       = data[14:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic signed [16:0] angle, logic signed [19:0] rate,
                                logic signed [15:0] left, logic signed [15:0] right);
            longint acc;
            longint bal;
            longint vel;
            longint lim;
            longint drive;
            longint wheel_sum;
            if (!odd_tick)
            begin
                odd_tick = 1'b1;
                return;
            end
            odd_tick = 1'b0;

            // pd balance term, q8.8 to whole units
            acc = (longint'(angle) - longint'(angle_offset)) * longint'(balance_kp)
                + longint'(rate) * longint'(balance_kd);
            bal = acc / 256;

            // low-pass of wheel speed, q15, round half up
            wheel_sum = longint'(right) - longint'(left);
            acc = filt_speed * longint'(smoothing)
                + wheel_sum * (Q15_ONE - longint'(smoothing)) * Q15_ONE;
            filt_speed = clamp((acc + 64'sd16384) >>> 15, WORD_MIN, WORD_MAX);

            // clamped integral
            lim = longint'(integral_limit) * Q15_ONE;
            speed_int = clamp(speed_int + filt_speed - longint'(movement) * Q15_ONE,
                              -lim, lim);

            // pi speed term, q23 to whole units
            acc = filt_speed * longint'(speed_kp) * 256 + speed_int * longint'(speed_ki);
            vel = acc / 64'sd8388608;

            drive = clamp(bal - vel, DRIVE_MIN, DRIVE_MAX);
            pending_drives.push_back(drive[23:0]);
        endfunction

        function void check_drive(logic signed [23:0] actual);
            logic signed [23:0] want;
            if (pending_drives.size() == 0)
            begin
                $display("%0t: unexpected motor_drive transfer, actual %0d", $time, actual);
                errors++;
                return;
            end
            want = pending_drives.pop_front();
            if (actual !== want)
            begin
                $display("%0t: motor_drive mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [16:0]    tilt_angle = '0;
    logic signed [19:0]    tilt_rate = '0;
    logic signed [15:0]    left_count = '0;
    logic signed [15:0]    right_count = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic signed [23:0]    motor_drive;
    bit                    calm = 1'b0;

    drive_scoreboard sb = new();

    balance_speed_cascade_controller DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tilt_angle  (tilt_angle),
        .tilt_rate   (tilt_rate),
        .left_count  (left_count),
        .right_count (right_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motor_drive (motor_drive)
    );

    always #2 clk = ~clk;

    // result side: random stall bursts
    always
    begin
        @(posedge clk);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
            sb.check_drive(motor_drive);
    end

    task automatic feed_tick(input int angle, input int rate, input int left, input int right);
        tilt_angle  <= 17'(angle);
        tilt_rate   <= 20'(rate);
        left_count  <= 16'(left);
        right_count <= 16'(right);
        in_valid    <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(17'(angle), 20'(rate), 16'(left), 16'(right));
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic random_tick();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            feed_tick($urandom_range(0, 4000) - 2000, $urandom_range(0, 40000) - 20000,
                      $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300);
        else if (mode < 8)
            feed_tick($urandom_range(0, 92160) - 46080, $urandom, $urandom, $urandom);
        else
            feed_tick($urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_drives.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        sb.set_reg(idx, CFG_DATA_W'(data));
    endtask

    task automatic set_all(input int offset, input int bkp, input int bkd, input int skp,
                           input int ski, input int smooth, input int limit, input int move);
        write_reg(CFG_ANGLE_OFFSET, offset);
        write_reg(CFG_BALANCE_KP, bkp);
        write_reg(CFG_BALANCE_KD, bkd);
        write_reg(CFG_SPEED_KP, skp);
        write_reg(CFG_SPEED_KI, ski);
        write_reg(CFG_SMOOTHING, smooth);
        write_reg(CFG_INTEGRAL_LIMIT, limit);
        write_reg(CFG_MOVEMENT, move);
        // unmapped index must leave every register alone
        write_reg(CFG_SPARE_BASE + 4'($urandom_range(0, 7)), $urandom);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_reg(input int lo, input int hi);
        if ($urandom_range(0, 7) == 0)
            return int'($urandom);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, extremes; every other tick is ignored by the block
        feed_tick(65535, 524287, 32767, 32767);
        feed_tick(0, 0, 0, 0);
        feed_tick(-65536, -524288, -32768, -32768);
        feed_tick(65535, 524287, -32768, 32767);
        feed_tick(0, 0, 0, 0);
        feed_tick(-65536, -524288, 32767, -32768);
        feed_tick(0, 0, 0, 0);
        feed_tick(46080, 0, 0, 0);
        feed_tick(0, 0, 0, 0);
        feed_tick(-46080, 100, 5, 5);
        // drive the integral into its clamp both ways
        for (int k = 0; k < 4; k++)
        begin
            feed_tick(0, 0, 0, 0);
            feed_tick(0, 0, -32768, 32767);
        end
        for (int k = 0; k < 4; k++)
        begin
            feed_tick(0, 0, 0, 0);
            feed_tick(12, -7, 32767, -32768);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_all(65535, 4095, 4095, 4095, 65535, 65535, 1048575, 16383);
                1: set_all(-65536, 0, 0, 0, 0, 0, 0, -16384);
                2: set_all(-46080, 4095, 4095, 4095, 65535, 32768, 1000000, 10000);
                3: set_all(46080, 300, 1, 80, 102, 29491, 10000, -10000);
                default:
                    set_all(pick_reg(-46080, 46080), pick_reg(0, 4095), pick_reg(0, 4095),
                            pick_reg(0, 4095), pick_reg(0, 65535), pick_reg(0, 32768),
                            pick_reg(0, 1000000), pick_reg(-10000, 10000));
            endcase
            calm = (ph == PHASES - 1);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
                random_tick();
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
